// File: sv/wps_pkg.sv
package wps_pkg;

  // Datapath width of the rotation stages: offsets are 33 bits, scaled by 2^8,
  // plus room for the CORDIC gain.
  localparam int CW = 44;

  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;
  // Reciprocal of 190, exact floor for the 23-bit quotient range used here.
  localparam logic [24:0] RECIP_190_Q32 = 25'd22605092;
  localparam logic [32:0] RECIP_3_Q33 = 33'h0_AAAA_AAAB;

  localparam logic [2:0] REG_ANGLE_TOL = 3'd0;
  localparam logic [2:0] REG_DIST_TOL = 3'd1;
  localparam logic [2:0] REG_DIST_INVALID = 3'd2;
  localparam logic [2:0] REG_ANGLE_INVALID = 3'd3;
  localparam logic [2:0] REG_DESIRED_SPEED = 3'd4;
  localparam logic [2:0] REG_STEER_GAIN = 3'd5;

  typedef struct packed {
    logic                 v;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
    logic                 zero;
    logic                 fin;
    logic [15:0]          heading;
  } cord_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// File: sv/waypoint_steering_step.sv
// Bearing-angle steering for one waypoint per item.
// Input stream s_*: one transfer carries target and pose positions, the
// heading and, in s_tuser, the final-waypoint flag. Output stream m_*: one
// transfer per input item with steering and speed commands, folded bearing,
// distance, reached and invalid flags, in input order.
// The cfg_* port writes the six tuning registers; write them only while the
// pipeline is empty.
// Items pass the input, pre-rotation, CORDIC and A to D register stages.
// Throughput is one item per cycle unless the output stalls: every stage,
// including the vectoring CORDIC with one rotation per stage, is a register
// stage. When the receiver holds m_tready low with a result waiting, the
// whole pipeline freezes and s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and returns the registers to their defaults.
module waypoint_steering_step #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // target_x, target_y, pose_x, pose_y, heading
  input  logic [143:0] s_tdata,
  // final_target
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // steer_cmd, speed_cmd, bearing_deg, distance, reached, invalid, zero fill
  output logic [87:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import wps_pkg::*;

  logic [14:0] angle_tolerance;
  logic [31:0] distance_tolerance;
  logic [31:0] distance_invalid;
  logic [14:0] bearing_limit;
  logic [15:0] speed_setpoint;
  logic [15:0] steer_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_tolerance    <= 15'd2560;
      distance_tolerance <= 32'd52429;
      distance_invalid   <= 32'd104858;
      bearing_limit      <= 15'd17920;
      speed_setpoint     <= 16'd256;
      steer_gain         <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ANGLE_TOL:     angle_tolerance    <= cfg_data[14:0];
        REG_DIST_TOL:      distance_tolerance <= cfg_data;
        REG_DIST_INVALID:  distance_invalid   <= cfg_data;
        REG_ANGLE_INVALID: bearing_limit      <= cfg_data[14:0];
        REG_DESIRED_SPEED: speed_setpoint     <= cfg_data[15:0];
        REG_STEER_GAIN:    steer_gain         <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_v;
  assign en       = !out_v || m_tready;
  assign s_tready = en;

  // Input stage: offsets.
  logic               in_v;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [15:0]        in_heading;
  logic               in_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (en) begin
      in_v       <= s_tvalid;
      dx         <= 33'($signed(s_tdata[31:0])) - 33'($signed(s_tdata[95:64]));
      dy         <= 33'($signed(s_tdata[63:32])) - 33'($signed(s_tdata[127:96]));
      in_heading <= s_tdata[143:128];
      in_fin     <= s_tuser[0];
    end
  end

  // Pre-rotation into the right half plane.
  cord_t chain [0:CORDIC_STAGES];
  cord_t pre_next;
  logic signed [CW-1:0] x0;
  logic signed [CW-1:0] y0;

  assign x0 = CW'(dx) <<< 8;
  assign y0 = CW'(dy) <<< 8;

  always_comb begin
    pre_next.v       = in_v;
    pre_next.zero    = (dx == '0) && (dy == '0);
    pre_next.fin     = in_fin;
    pre_next.heading = in_heading;
    pre_next.x       = x0;
    pre_next.y       = y0;
    pre_next.z       = '0;
    if (x0[CW-1]) begin
      if (!y0[CW-1]) begin
        pre_next.x = y0;
        pre_next.y = -x0;
        pre_next.z = QUARTER_TURN;
      end else begin
        pre_next.x = -y0;
        pre_next.y = x0;
        pre_next.z = THREE_QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) chain[0].v <= 1'b0;
    else if (en) chain[0] <= pre_next;
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    wps_cordic_stage #(.IDX(g)) u_stage (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (chain[g]),
      .q   (chain[g+1])
    );
  end

  // Stage A: bearing fold and magnitude partial products.
  cord_t              cf;
  logic [31:0]        u;
  logic signed [31:0] s_raw;
  logic signed [31:0] s_fold;
  logic               rev_next;
  logic signed [37:0] s45;
  logic [CW-1:0]      mag;

  assign cf = chain[CORDIC_STAGES];

  always_comb begin
    u        = {cf.heading, 16'h0000} - cf.z;
    s_raw    = cf.zero ? 32'sd0 : $signed(u);
    s_fold   = s_raw;
    rev_next = 1'b0;
    if (s_raw > 32'sh4000_0000) begin
      s_fold   = s_raw - 32'sh8000_0000;
      rev_next = 1'b1;
    end else if (s_raw < -32'sh4000_0000) begin
      s_fold   = s_raw + 32'sh8000_0000;
      rev_next = 1'b1;
    end
    s45 = 38'(s_fold) * 38'sd45 + 38'sd1048576;
    mag = cf.zero ? '0 : cf.x;
  end

  logic               a_v;
  logic signed [15:0] a_bearing;
  logic               a_rev;
  logic               a_fin;
  logic [55:0]        a_ph;
  logic [51:0]        a_pl;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v       <= cf.v;
      a_bearing <= 16'(s45 >>> 21);
      a_rev     <= rev_next;
      a_fin     <= cf.fin;
      a_ph      <= 56'(mag[CW-1:20]) * 56'(INV_GAIN_Q32);
      a_pl      <= 52'(mag[19:0]) * 52'(INV_GAIN_Q32);
    end
  end

  // Stage B: distance rounding, gain product, final tolerance.
  logic [56:0]        t_sum;
  logic [56:0]        t_rnd;
  logic signed [32:0] gp;
  logic [31:0]        gp_abs;
  logic [65:0]        tol3_full;

  assign t_sum     = 57'(a_ph) + 57'(a_pl[51:20]);
  assign t_rnd     = t_sum + 57'd524288;
  assign gp        = 33'(a_bearing) * $signed({17'd0, steer_gain});
  assign gp_abs    = gp[32] ? 32'(-gp) : gp[31:0];
  assign tol3_full = 66'(distance_tolerance) * 66'(RECIP_3_Q33);

  logic               b_v;
  logic signed [15:0] b_bearing;
  logic [15:0]        b_absb;
  logic               b_rev;
  logic               b_fin;
  logic [31:0]        b_dist;
  logic               b_neg;
  logic [22:0]        b_vmag;
  logic [31:0]        b_tol3;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v       <= a_v;
      b_bearing <= a_bearing;
      b_absb    <= a_bearing[15] ? 16'(-a_bearing) : a_bearing;
      b_rev     <= a_rev;
      b_fin     <= a_fin;
      b_dist    <= (t_rnd[56:52] != '0) ? 32'hFFFF_FFFF : t_rnd[51:20];
      b_neg     <= gp[32];
      b_vmag    <= gp_abs[30:8];
      b_tol3    <= tol3_full[64:33];
    end
  end

  // Stage C: quotient by 190 and the limit compares.
  logic [47:0] qprod;
  logic [31:0] tol;
  assign qprod = 48'(b_vmag) * 48'(RECIP_190_Q32);
  assign tol   = b_fin ? b_tol3 : distance_tolerance;

  logic               c_v;
  logic signed [15:0] c_bearing;
  logic               c_rev;
  logic [31:0]        c_dist;
  logic               c_neg;
  logic [15:0]        c_q;
  logic               c_inval;
  logic               c_reach;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v       <= b_v;
      c_bearing <= b_bearing;
      c_rev     <= b_rev;
      c_dist    <= b_dist;
      c_neg     <= b_neg;
      c_q       <= qprod[47:32];
      c_inval   <= (b_absb > 16'(bearing_limit)) || (b_dist > distance_invalid);
      c_reach   <= (b_dist < tol) && (b_absb < 16'(angle_tolerance));
    end
  end

  // Stage D: output register.
  logic signed [15:0] out_steer;
  logic signed [16:0] out_speed;
  logic signed [15:0] out_bearing;
  logic [31:0]        out_dist;
  logic               out_reach;
  logic               out_inval;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v       <= c_v;
      out_bearing <= c_bearing;
      out_dist    <= c_dist;
      out_reach   <= c_reach;
      out_inval   <= c_inval;
      if (c_inval) begin
        out_steer <= '0;
        out_speed <= '0;
      end else begin
        out_steer <= c_neg ? -c_q : c_q;
        out_speed <= c_rev ? -17'({1'b0, speed_setpoint}) : 17'({1'b0, speed_setpoint});
      end
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {5'd0, out_inval, out_reach, out_dist, out_bearing,
                     out_speed, out_steer};

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_inval) |-> (out_steer == 16'sd0 && out_speed == 17'sd0))
    else $error("commands not zero on invalid result");

  a_bearing_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_bearing <= 16'sd23040 && out_bearing >= -16'sd23040))
    else $error("folded bearing out of range");

  a_reach_dist: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_reach) |-> (out_dist < distance_tolerance))
    else $error("reached with distance above tolerance");

endmodule

// File: sv/wps_cordic_stage.sv
module wps_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  wps_pkg::cord_t d,
  output wps_pkg::cord_t q
);
  import wps_pkg::*;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic [31:0]          a;
  cord_t                q_next;

  assign xs = d.x >>> IDX;
  assign ys = d.y >>> IDX;
  assign a  = atan_lut(5'(IDX));

  always_comb begin
    q_next = d;
    if (!d.y[CW-1]) begin
      q_next.x = d.x + ys;
      q_next.y = d.y - xs;
      q_next.z = d.z + a;
    end else begin
      q_next.x = d.x - ys;
      q_next.y = d.y + xs;
      q_next.z = d.z - a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) q.v <= 1'b0;
    else if (en) q <= q_next;
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import wps_pkg::*;

  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [15:0]        heading;
    logic               fin;
  } waypoint_t;

  typedef struct packed {
    logic [15:0] steer;
    logic [16:0] speed;
    logic [15:0] bearing;
    logic [31:0] distance;
    logic        reached;
    logic        invalid;
  } command_t;

  // Floor shift for signed 64-bit values.
  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-(v + 1)) >>> s) - 1;
  endfunction

  class steering_scoreboard;
    bit [14:0] ang_tol;
    bit [31:0] dist_tol;
    bit [31:0] dist_inv;
    bit [14:0] ang_inv;
    bit [15:0] speed_set;
    bit [15:0] gain;
    command_t  pending[$];
    int        errors;
    longint unsigned atans[32];

    function new();
      atans = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
                64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
                64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
                64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000};
      ang_tol = 2560; dist_tol = 52429; dist_inv = 104858;
      ang_inv = 17920; speed_set = 256; gain = 256;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_ANGLE_TOL:     ang_tol = val[14:0];
        REG_DIST_TOL:      dist_tol = val;
        REG_DIST_INVALID:  dist_inv = val;
        REG_ANGLE_INVALID: ang_inv = val[14:0];
        REG_DESIRED_SPEED: speed_set = val[15:0];
        REG_STEER_GAIN:    gain = val[15:0];
        default: ;
      endcase
    endfunction

    function void note_waypoint(waypoint_t w);
      longint dx, dy, x, y, t, xs, ys, s, bearing, absb, steer, speed, mag;
      bit [31:0] z, u;
      longint unsigned dist_q, hi, lo, tp, tol;
      int dir;
      command_t c;
      dx = longint'(w.tx) - longint'(w.px);
      dy = longint'(w.ty) - longint'(w.py);
      s = 0; dist_q = 0; dir = 1; steer = 0; speed = 0;
      if (dx != 0 || dy != 0) begin
        x = dx * 256; y = dy * 256; z = 0;
        if (x < 0) begin
          if (y >= 0) begin t = x; x = y; y = -t; z = QUARTER_TURN; end
          else begin t = x; x = -y; y = t; z = THREE_QUARTER_TURN; end
        end
        for (int i = 0; i < 16; i++) begin
          xs = floor_shift(x, i); ys = floor_shift(y, i);
          if (y >= 0) begin x += ys; y -= xs; z += atans[i][31:0]; end
          else begin x -= ys; y += xs; z -= atans[i][31:0]; end
        end
        mag = x;
        u = {w.heading, 16'h0} - z;
        s = longint'($signed(u));
        hi = longint'(mag) >> 20;
        lo = mag & 64'hFFFFF;
        tp = hi * 64'd2608131496 + ((lo * 64'd2608131496) >> 20);
        dist_q = (tp + (64'd1 << 19)) >> 20;
        if (dist_q > 64'hFFFFFFFF) dist_q = 64'hFFFFFFFF;
      end
      if (s > 64'sh40000000) begin s -= 64'sh80000000; dir = -1; end
      else if (s < -64'sh40000000) begin s += 64'sh80000000; dir = -1; end
      bearing = floor_shift(s * 45 + (64'sd1 << 20), 21);
      absb = bearing < 0 ? -bearing : bearing;
      c.invalid = absb > longint'(ang_inv) || dist_q > dist_inv;
      if (!c.invalid) begin
        steer = (bearing * longint'(gain)) / (190 * 256);
        speed = dir * longint'(speed_set);
      end
      tol = w.fin ? dist_tol / 3 : dist_tol;
      c.reached = dist_q < tol && absb < longint'(ang_tol);
      c.steer = steer[15:0];
      c.speed = speed[16:0];
      c.bearing = bearing[15:0];
      c.distance = dist_q[31:0];
      pending.push_back(c);
    endfunction

    function void check_command(command_t got);
      command_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.steer !== e.steer)
        $display("%0t: steer expected %h actual %h", $time, e.steer, got.steer);
      if (got.speed !== e.speed)
        $display("%0t: speed expected %h actual %h", $time, e.speed, got.speed);
      if (got.bearing !== e.bearing)
        $display("%0t: bearing expected %h actual %h", $time, e.bearing, got.bearing);
      if (got.distance !== e.distance)
        $display("%0t: distance expected %h actual %h", $time, e.distance, got.distance);
      if (got.reached !== e.reached)
        $display("%0t: reached expected %b actual %b", $time, e.reached, got.reached);
      if (got.invalid !== e.invalid)
        $display("%0t: invalid expected %b actual %b", $time, e.invalid, got.invalid);
      if (got !== e) errors++;
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [87:0]  m_tdata;
  logic         cfg_we = 0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  steering_scoreboard sb = new();
  bit hold_off = 0;
  bit stim_done = 0;
  int idle_cycles = 0;

  waypoint_steering_step u_dut (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Output side: accept and check.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      command_t got;
      got.steer = m_tdata[15:0];
      got.speed = m_tdata[32:16];
      got.bearing = m_tdata[48:33];
      got.distance = m_tdata[80:49];
      got.reached = m_tdata[81];
      got.invalid = m_tdata[82];
      sb.check_command(got);
    end
  end

  // Receiver stall pattern, with a long hold-off when asked.
  always @(posedge clk) begin
    int ph;
    ph = $urandom_range(0, 99);
    if (hold_off) m_tready <= 0;
    else if (($time / 400) % 3 == 0) m_tready <= 1;
    else m_tready <= ph < 65;
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_waypoint(waypoint_t w);
    s_tvalid <= 1;
    s_tdata <= {w.heading, w.py, w.px, w.ty, w.tx};
    s_tuser <= w.fin;
    do @(posedge clk); while (!s_tready);
    sb.note_waypoint(w);
  endtask

  task automatic pause_sender();
    s_tvalid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $signed($urandom_range(0, 400000)) - 200000;
    endcase
  endfunction

  function automatic waypoint_t rand_waypoint();
    waypoint_t w;
    w.px = rand_pos(); w.py = rand_pos();
    case ($urandom_range(0, 3))
      0: begin w.tx = rand_pos(); w.ty = rand_pos(); end
      1: begin w.tx = w.px; w.ty = w.py; end
      default: begin
        w.tx = w.px + ($signed($urandom_range(0, 200000)) - 100000);
        w.ty = w.py + ($signed($urandom_range(0, 200000)) - 100000);
      end
    endcase
    w.heading = 16'($urandom());
    w.fin = 1'($urandom());
    return w;
  endfunction

  function automatic waypoint_t mk(int tx, int ty, int px, int py, int h, bit f);
    waypoint_t w;
    w.tx = tx; w.ty = ty; w.px = px; w.py = py; w.heading = 16'(h); w.fin = f;
    return w;
  endfunction

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst && n > 0; i++, n--) send_waypoint(rand_waypoint());
      if ($urandom_range(0, 3) != 0) pause_sender();
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: coincident points, fold boundaries, extremes.
    send_waypoint(mk(0, 0, 0, 0, 0, 0));
    send_waypoint(mk(65536, 0, 0, 0, 16'h4000, 0));
    send_waypoint(mk(65536, 0, 0, 0, 16'hC000, 1));
    send_waypoint(mk(65536, 0, 0, 0, 16'h8000, 0));
    send_waypoint(mk(-65536, 0, 0, 0, 0, 1));
    send_waypoint(mk(0, 65536, 0, 0, 16'h4000, 0));
    send_waypoint(mk(0, -65536, 0, 0, 16'h7FFF, 1));
    send_waypoint(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 16'h2000, 0));
    send_waypoint(mk(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hA000, 1));
    send_waypoint(mk(1000, 100, 0, 0, 0, 1));
    send_waypoint(mk(20000, 0, 0, 0, 0, 0));
    send_waypoint(mk(-1, -1, 0, 0, 16'hFFFF, 0));
    drain();

    random_phase(400);

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_phase(150);
    join

    write_cfg(REG_ANGLE_TOL, 32'd23040);
    write_cfg(REG_DIST_TOL, 32'hFFFFFFFF);
    write_cfg(REG_DIST_INVALID, 32'hFFFFFFFF);
    write_cfg(REG_ANGLE_INVALID, 32'd23040);
    write_cfg(REG_DESIRED_SPEED, 32'hFFFF);
    write_cfg(REG_STEER_GAIN, 32'hFFFF);
    random_phase(450);

    write_cfg(REG_ANGLE_TOL, 32'd0);
    write_cfg(REG_DIST_TOL, 32'd0);
    write_cfg(REG_DIST_INVALID, 32'd0);
    write_cfg(REG_ANGLE_INVALID, 32'd0);
    write_cfg(REG_DESIRED_SPEED, 32'd0);
    write_cfg(REG_STEER_GAIN, 32'd0);
    random_phase(300);

    for (int k = 0; k < 3; k++) begin
      write_cfg(REG_ANGLE_TOL, $urandom());
      write_cfg(REG_DIST_TOL, $urandom());
      write_cfg(REG_DIST_INVALID, $urandom());
      write_cfg(REG_ANGLE_INVALID, $urandom());
      write_cfg(REG_DESIRED_SPEED, $urandom());
      write_cfg(REG_STEER_GAIN, $urandom());
      random_phase(200);
    end

    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
